@@ rtl/aes_pkg.sv @@
`timescale 1ns / 1ps
package aes_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 64;
   localparam int RoundKeyWordsDefault = 60;
   localparam int BlockWords = 4;

   localparam logic [CsrIndexWidth-1:0] CSR_KEY_LENGTH = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_0 = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_1 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_2 = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_3 = 3'd4;

   localparam logic [1:0] KEY_LEN_128 = 2'd0;
   localparam logic [1:0] KEY_LEN_192 = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_LOAD,
      ST_BYTE,
      ST_MIX,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic         decrypt;
      logic [127:0] block;
   } req_type;

   typedef struct packed {
      logic [127:0] block;
   } rsp_type;

   function automatic logic [7:0] xtime(input logic [7:0] x);
      xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] p;
      logic [7:0] t;
      p = 8'h00;
      t = a;
      for (int k = 0; k < 4; k++) begin
         if (b[k]) p = p ^ t;
         t = xtime(t);
      end
      gmul = p;
   endfunction

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

endpackage

@@ rtl/aes_stream_if.sv @@
`timescale 1ns / 1ps
interface aes_stream_if #(
   parameter int Width = 129
);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/aes_ram.sv @@
`timescale 1ns / 1ps
module aes_ram #(
   parameter int Width = 32,
   parameter int Depth = 60
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ rtl/aes_byte_unit.sv @@
`timescale 1ns / 1ps
// One byte per cycle: S-box or inverse S-box lookup.
module aes_byte_unit (
   input  logic       decrypt,
   input  logic [7:0] din,
   output logic [7:0] dout
);
   import aes_pkg::*;

   always_comb begin
      dout = decrypt ? INV_SBOX[din] : SBOX[din];
   end
endmodule

@@ rtl/aes_block_cipher.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Payload                              Handshake
// req      in   {mode, block_high, block_low}        req_valid / req_ready
// rsp      out  {result_high, result_low}            rsp_valid / rsp_ready
// csr      in   csr_index, csr_data                  csr_write_enable
//
// Byte-serial datapath: one byte a cycle through a single S-box unit, one column
// a cycle through a MixColumns unit. A middle round substitutes all 16 bytes,
// mixes the 4 columns and loads the round key; the opening key add is a key load
// alone and the last round has no mix (Nr is 10, 12 or 14).
// After a key write, the first block first expands the key one word per cycle.
// Reset is synchronous and clears control and the key registers only.
// A finished block holds in the result register until rsp_ready.
module aes_block_cipher #(
   parameter int RoundKeyWords = aes_pkg::RoundKeyWordsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   aes_stream_if.sink                         req,
   aes_stream_if.source                       rsp,
   input  logic                               csr_write_enable,
   input  logic [aes_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [aes_pkg::CsrDataWidth-1:0]   csr_data
);
   import aes_pkg::*;

   localparam int AddrWidth = $clog2(RoundKeyWords);
   localparam int CountWidth = $clog2(RoundKeyWords + 8) + 1;

   state_type state_ff, state_in;

   logic [1:0]   key_len_ff;
   logic [255:0] key_ff;
   logic         stale_ff, stale_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff <= KEY_LEN_128;
         key_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_LENGTH: key_len_ff <= csr_data[1:0];
            CSR_KEY_0: key_ff[255:192] <= csr_data;
            CSR_KEY_1: key_ff[191:128] <= csr_data;
            CSR_KEY_2: key_ff[127:64] <= csr_data;
            CSR_KEY_3: key_ff[63:0] <= csr_data;
            default: ;
         endcase
      end
   end

   logic csr_hit;
   assign csr_hit = csr_write_enable && (csr_index <= CSR_KEY_3);

   logic [3:0] nk;
   always_comb begin
      priority if (key_len_ff == KEY_LEN_128) nk = 4'd4;
      else if (key_len_ff == KEY_LEN_192) nk = 4'd6;
      else nk = 4'd8;
   end
   logic [3:0] nr;
   assign nr = nk + 4'd6;
   logic [CountWidth-1:0] total_words;
   assign total_words = CountWidth'(BlockWords) * CountWidth'(nr + 4'd1);

   // Key expansion: window of last 8 words kept in registers.
   logic [31:0] win_ff [8], win_in [8];
   logic [CountWidth-1:0] widx_ff, widx_in;
   logic [3:0] wmod_ff, wmod_in;
   logic [7:0] rcon_ff, rcon_in;
   logic [2:0] win_top;
   assign win_top = 3'(nk - 4'd1);

   logic [31:0] prev_w, rot_w, sub_in_w, sub_w, new_w;
   assign prev_w = win_ff[win_top];
   assign rot_w = {prev_w[23:0], prev_w[31:24]};
   assign sub_in_w = (wmod_ff == 4'd0) ? rot_w : prev_w;
   assign sub_w = {SBOX[sub_in_w[31:24]], SBOX[sub_in_w[23:16]],
                   SBOX[sub_in_w[15:8]], SBOX[sub_in_w[7:0]]};
   always_comb begin
      if (widx_ff < CountWidth'(nk)) begin
         new_w = key_ff[255 - 32*widx_ff[2:0] -: 32];
      end else if (wmod_ff == 4'd0) begin
         new_w = win_ff[0] ^ sub_w ^ {rcon_ff, 24'h0};
      end else if (nk == 4'd8 && wmod_ff == 4'd4) begin
         new_w = win_ff[0] ^ sub_w;
      end else begin
         new_w = win_ff[0] ^ prev_w;
      end
   end

   // Round key store.
   logic                 rk_we;
   logic [AddrWidth-1:0] rk_waddr, rk_raddr;
   logic [31:0]          rk_rdata;
   aes_ram #(.Width(32), .Depth(RoundKeyWords)) u_rk (
      .clock(clock), .wr_en(rk_we), .wr_addr(rk_waddr), .wr_data(new_w),
      .rd_addr(rk_raddr), .rd_data(rk_rdata)
   );
   assign rk_waddr = widx_ff[AddrWidth-1:0];

   // Block state, byte-serial.
   logic [127:0] st_ff, st_in;
   logic         dec_ff, dec_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [127:0] res_ff, res_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [7:0] sb_out;
   aes_byte_unit u_byte (.decrypt(dec_ff), .din(st_ff[127:120]), .dout(sb_out));

   // Shift rows on the 16-byte word (byte 0 at top).
   function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      t = s;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (inv)
               t[127 - 8*(4*((c + r) % 4) + r) -: 8] = s[127 - 8*(4*c + r) -: 8];
            else
               t[127 - 8*(4*c + r) -: 8] = s[127 - 8*(4*((c + r) % 4) + r) -: 8];
         end
      end
      shift_rows = t;
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
      logic [7:0] b [4];
      logic [7:0] m [4];
      logic [31:0] o;
      for (int k = 0; k < 4; k++) b[k] = col[31 - 8*k -: 8];
      if (inv) begin
         m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
      end else begin
         m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
      end
      o = '0;
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 4; k++)
            o[31 - 8*r -: 8] = o[31 - 8*r -: 8] ^ gmul(b[k], m[(k + 4 - r) % 4][3:0]);
      end
      mix_col = o;
   endfunction

   // Phase in ST_LOAD: cnt 0..4 fetches four key words of the current round.
   logic [3:0] cur_round;
   logic last_round;
   assign cur_round = rnd_ff;
   assign last_round = dec_ff ? (rnd_ff == 4'd0) : (rnd_ff == nr);

   logic [CountWidth-1:0] rd_word;
   assign rd_word = CountWidth'(cur_round) * CountWidth'(BlockWords) + CountWidth'(cnt_ff[1:0]);
   assign rk_raddr = rd_word[AddrWidth-1:0];

   // words past the store read as zero; flag follows the registered read
   logic rk_hit_ff, rk_hit_in;
   assign rk_hit_in = (rd_word < CountWidth'(RoundKeyWords));

   logic [127:0] mix_st;
   assign mix_st = {st_ff[95:0], mix_col(st_ff[127:96], dec_ff)};

   req_type req_p;
   assign req_p = req.payload;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_type'(res_ff);

   logic first_ark_ff, first_ark_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stale_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stale_ff <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      st_ff <= st_in;
      dec_ff <= dec_in;
      rnd_ff <= rnd_in;
      cnt_ff <= cnt_in;
      rkey_ff <= rkey_in;
      res_ff <= res_in;
      widx_ff <= widx_in;
      wmod_ff <= wmod_in;
      rcon_ff <= rcon_in;
      first_ark_ff <= first_ark_in;
      rk_hit_ff <= rk_hit_in;
      for (int i = 0; i < 8; i++) win_ff[i] <= win_in[i];
   end

   always_comb begin
      state_in = state_ff;
      stale_in = stale_ff | csr_hit;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      st_in = st_ff;
      dec_in = dec_ff;
      rnd_in = rnd_ff;
      cnt_in = cnt_ff;
      rkey_in = rkey_ff;
      res_in = res_ff;
      widx_in = widx_ff;
      wmod_in = wmod_ff;
      rcon_in = rcon_ff;
      first_ark_in = first_ark_ff;
      rk_we = 1'b0;
      for (int i = 0; i < 8; i++) win_in[i] = win_ff[i];

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               st_in = req_p.block;
               dec_in = req_p.decrypt;
               rnd_in = req_p.decrypt ? nr : 4'd0;
               cnt_in = '0;
               first_ark_in = 1'b1;
               widx_in = '0;
               wmod_in = '0;
               rcon_in = 8'h01;
               state_in = stale_ff ? ST_EXPAND : ST_LOAD;
            end
         end
         ST_EXPAND: begin
            // One key word a cycle; window shifts with newest at nk-1.
            // Words past the store are dropped and read back as zero.
            rk_we = (widx_ff < CountWidth'(RoundKeyWords));
            for (int i = 0; i < 7; i++) win_in[i] = win_ff[i + 1];
            win_in[win_top] = rk_we ? new_w : 32'h0;
            if (widx_ff >= CountWidth'(nk) && wmod_ff == 4'd0) rcon_in = xtime(rcon_ff);
            widx_in = widx_ff + 1'b1;
            wmod_in = (wmod_ff == nk - 4'd1) ? 4'd0 : wmod_ff + 4'd1;
            if (widx_ff == total_words - 1'b1) begin
               stale_in = csr_hit;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // cnt 0..3 issue reads, 1..4 capture data.
            if (cnt_ff != 5'd0) begin
               rkey_in = {rkey_ff[95:0], rk_hit_ff ? rk_rdata : 32'h0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd4) begin
               cnt_in = '0;
               if (first_ark_ff) begin
                  first_ark_in = 1'b0;
                  rnd_in = dec_ff ? rnd_ff - 4'd1 : rnd_ff + 4'd1;
                  st_in = shift_rows(st_ff ^ rkey_in, dec_ff);
                  state_in = ST_BYTE;
               end else if (last_round) begin
                  st_in = st_ff ^ rkey_in;
                  res_in = st_ff ^ rkey_in;
                  rsp_valid_in = 1'b1;
                  state_in = ST_DONE;
               end else if (!dec_ff) begin
                  // encrypt: key add closes the round, next round starts
                  rnd_in = rnd_ff + 4'd1;
                  st_in = shift_rows(st_ff ^ rkey_in, 1'b0);
                  state_in = ST_BYTE;
               end else begin
                  // decrypt: inverse mix follows the key add
                  st_in = st_ff ^ rkey_in;
                  state_in = ST_MIX;
               end
            end
         end
         ST_BYTE: begin
            // Substitute one byte a cycle, rotating the state.
            st_in = {st_ff[119:0], sb_out};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) begin
               cnt_in = '0;
               state_in = (!dec_ff && !last_round) ? ST_MIX : ST_LOAD;
            end
         end
         ST_MIX: begin
            // One column a cycle; encrypt mixes before the key, decrypt after.
            st_in = mix_st;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               cnt_in = '0;
               if (dec_ff) begin
                  rnd_in = rnd_ff - 4'd1;
                  st_in = shift_rows(mix_st, 1'b1);
                  state_in = ST_BYTE;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready)
      else $error("input taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(res_ff)))
      else $error("result dropped");
   a_expand_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && $past(state_ff) == ST_EXPAND && !$past(csr_hit)) |-> !stale_ff)
      else $error("key store still stale");
`endif
endmodule
